// ===== rtl/dvsr_pkg.sv =====
// Package with shared constants and types for the dword value scan and refine block.
`timescale 1ns / 1ps

package dvsr_pkg;

  // Candidate list geometry.
  localparam int LIST_DEPTH = 1024;
  localparam int LIST_AW    = $clog2(LIST_DEPTH);
  localparam int CNT_W      = LIST_AW + 1;

  // Scanned memory geometry.
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
  localparam int ADDR_W     = 32;

  // Payload widths.
  localparam int DATA_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int WIN_W      = 3 * BYTE_W;
  localparam int IDX_W      = 10;
  localparam int REQ_W      = 3;

  // Request codes carried on the input tuser.
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 3'd0,
    REQ_SCAN   = 3'd1,
    REQ_BEGIN  = 3'd2,
    REQ_RESULT = 3'd3,
    REQ_READ   = 3'd4
  } req_t;

  // Control sent from the sequencer to the scan window.
  typedef struct packed {
    logic clear;
    logic shift;
  } win_ctl_t;

endpackage

// ===== rtl/dvsr_list_mem.sv =====
// Candidate address list: one write port and one registered read port.
`timescale 1ns / 1ps

module dvsr_list_mem (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [dvsr_pkg::LIST_AW-1:0]      wr_addr,
  input  logic [dvsr_pkg::ADDR_W-1:0]       wr_data,
  input  logic                              rd_en,
  input  logic [dvsr_pkg::LIST_AW-1:0]      rd_addr,
  output logic [dvsr_pkg::ADDR_W-1:0]       rd_data
);
  import dvsr_pkg::*;

  logic [ADDR_W-1:0] mem [LIST_DEPTH];
  logic [ADDR_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/dvsr_window.sv =====
// Sliding four-byte little-endian window that restarts at every page start.
`timescale 1ns / 1ps

module dvsr_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dvsr_pkg::win_ctl_t            ctl,
  input  logic [dvsr_pkg::BYTE_W-1:0]   byte_value,
  input  logic [dvsr_pkg::ADDR_W-1:0]   byte_address,
  input  logic [dvsr_pkg::DATA_W-1:0]   search_value,
  output logic                          hit
);
  import dvsr_pkg::*;

  logic [WIN_W-1:0] win_r, win_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic [1:0]       fill_eff;
  logic             page_start;

  // A byte at a page start begins a fresh window.
  assign page_start = (byte_address[PAGE_BITS-1:0] == '0);
  assign fill_eff   = page_start ? 2'd0 : fill_r;
  assign hit        = (fill_eff == 2'd3) && ({byte_value, win_r} == search_value);

  // Shift the new byte in at the top; the fill count saturates at three.
  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    if (ctl.clear) begin
      win_nxt  = '0;
      fill_nxt = '0;
    end else if (ctl.shift) begin
      win_nxt  = {byte_value, win_r[WIN_W-1:BYTE_W]};
      fill_nxt = (fill_eff == 2'd3) ? 2'd3 : fill_eff + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      fill_r <= '0;
    end else begin
      win_r  <= win_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== rtl/dword_value_scan_and_refine.sv =====
// Top level: request sequencer, list bookkeeping and the stream ports.
`timescale 1ns / 1ps

// Scans a byte stream for a 32-bit value and keeps a list of match addresses.
// Input stream: in_tuser carries the request code (clear, scan byte, begin
// refine, refine read result, read entry); in_tdata carries the operands.
// Each request yields exactly one result transfer on the output stream:
// out_tuser is the match flag, out_tlast marks the end of a refine pass and
// out_tdata carries the address, the list count and the full flag.
// Clear, scan, begin refine and unknown codes register their result at the
// edge that accepts the request. Refine results and entry reads that touch
// the list pass through S_READ, where the registered read of the list memory
// returns the entry; those that find nothing to read register at acceptance.
// The block handles one request at a time and takes the next request while a
// result waits, as long as that result is taken in the same cycle.
// A stalled receiver holds the result register and thus in_tready low.
// The search value is written on the cfg channel, which is always ready.
// Synchronous reset empties the list, clears the window, the full flag and
// any refine in progress; the list memory itself is not cleared.
module dword_value_scan_and_refine (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: search value.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // Request stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // byte_value[7:0], byte_address[39:8], read_ok[40], read_value[72:41],
  // entry_index[82:73], zero[87:83]
  input  logic [87:0] in_tdata,
  // req_type[2:0]
  input  logic [2:0]  in_tuser,
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // match_address[31:0], list_count[42:32], list_full[43], zero[47:44]
  output logic [47:0] out_tdata,
  // match[0]
  output logic [0:0]  out_tuser,
  // refine_done
  output logic        out_tlast
);
  import dvsr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  // Request fields.
  req_t              req;
  logic [BYTE_W-1:0] f_byte;
  logic [ADDR_W-1:0] f_addr;
  logic              f_ok;
  logic [DATA_W-1:0] f_val;
  logic [IDX_W-1:0]  f_idx;

  assign req    = req_t'(in_tuser);
  assign f_byte = in_tdata[7:0];
  assign f_addr = in_tdata[39:8];
  assign f_ok   = in_tdata[40];
  assign f_val  = in_tdata[72:41];
  assign f_idx  = in_tdata[82:73];

  // Control and payload registers.
  state_t            state_r, state_nxt;
  logic [DATA_W-1:0] search_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  orig_r, orig_nxt;
  logic              ovf_r, ovf_nxt;
  logic              keep_r, keep_nxt;
  logic              pend_rd_r, pend_rd_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_match_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_full_r;
  logic              out_done_r;

  // Result being formed this cycle.
  logic              load_out;
  logic              res_match;
  logic [ADDR_W-1:0] res_addr;
  logic              res_done;

  // List memory and window hookup.
  logic               mem_we, mem_re;
  logic [LIST_AW-1:0] mem_waddr, mem_raddr;
  logic [ADDR_W-1:0]  mem_wdata, mem_rdata;
  win_ctl_t           win_ctl;
  logic               win_hit;
  logic               in_acc;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  dvsr_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (win_ctl),
    .byte_value   (f_byte),
    .byte_address (f_addr),
    .search_value (search_r),
    .hit          (win_hit)
  );

  dvsr_list_mem u_list (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // Request sequencer: decode, list reads, appending and compacting writes.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    orig_nxt    = orig_r;
    ovf_nxt     = ovf_r;
    keep_nxt    = keep_r;
    pend_rd_nxt = pend_rd_r;
    load_out    = 1'b0;
    res_match   = 1'b0;
    res_addr    = '0;
    res_done    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = count_r[LIST_AW-1:0];
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = idx_r[LIST_AW-1:0];
    win_ctl     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (req)
            REQ_CLEAR: begin
              count_nxt     = '0;
              ovf_nxt       = 1'b0;
              orig_nxt      = '0;
              idx_nxt       = '0;
              win_ctl.clear = 1'b1;
              load_out      = 1'b1;
            end
            REQ_SCAN: begin
              // A scan abandons any refine still in progress.
              if (idx_r < orig_r) begin
                orig_nxt = '0;
                idx_nxt  = '0;
              end
              win_ctl.shift = 1'b1;
              if (win_hit) begin
                res_match = 1'b1;
                res_addr  = f_addr - ADDR_W'(3);
                if (count_r < CNT_W'(LIST_DEPTH)) begin
                  mem_we    = 1'b1;
                  mem_wdata = f_addr - ADDR_W'(3);
                  count_nxt = count_r + CNT_W'(1);
                end else begin
                  ovf_nxt = 1'b1;
                end
              end
              load_out = 1'b1;
            end
            REQ_BEGIN: begin
              orig_nxt  = count_r;
              idx_nxt   = '0;
              count_nxt = '0;
              res_done  = (count_r == '0);
              load_out  = 1'b1;
            end
            REQ_RESULT: begin
              if (idx_r < orig_r) begin
                mem_re      = 1'b1;
                mem_raddr   = idx_r[LIST_AW-1:0];
                keep_nxt    = f_ok && (f_val == search_r);
                pend_rd_nxt = 1'b0;
                state_nxt   = S_READ;
              end else begin
                load_out = 1'b1;
              end
            end
            REQ_READ: begin
              if ({1'b0, f_idx} < count_r) begin
                mem_re      = 1'b1;
                mem_raddr   = f_idx[LIST_AW-1:0];
                pend_rd_nxt = 1'b1;
                state_nxt   = S_READ;
              end else begin
                load_out = 1'b1;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        load_out  = 1'b1;
        state_nxt = S_IDLE;
        if (pend_rd_r) begin
          res_match = 1'b1;
          res_addr  = mem_rdata;
        end else begin
          // Compact in place: the write slot never passes the read slot.
          if (keep_r && (count_r < CNT_W'(LIST_DEPTH))) begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
            count_nxt = count_r + CNT_W'(1);
            res_match = 1'b1;
            res_addr  = mem_rdata;
          end
          idx_nxt = idx_r + CNT_W'(1);
          if ((idx_r + CNT_W'(1)) == orig_r) begin
            res_done = 1'b1;
            orig_nxt = '0;
            idx_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register holds until the receiver takes it.
  assign out_valid_nxt = load_out ? 1'b1 : (out_valid_r && !out_tready);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      search_r    <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      orig_r      <= '0;
      ovf_r       <= 1'b0;
      keep_r      <= 1'b0;
      pend_rd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      orig_r      <= orig_nxt;
      ovf_r       <= ovf_nxt;
      keep_r      <= keep_nxt;
      pend_rd_r   <= pend_rd_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        search_r <= cfg_data;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_match_r <= res_match;
      out_addr_r  <= res_addr;
      out_count_r <= count_nxt;
      out_full_r  <= ovf_nxt;
      out_done_r  <= res_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_full_r, out_count_r, out_addr_r};
  assign out_tuser  = out_match_r;
  assign out_tlast  = out_done_r;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the dword value scan and refine block.
`timescale 1ns / 1ps

module tb;
  import dvsr_pkg::*;

  // Highest code that fits the request field; codes above REQ_READ are unknown.
  localparam logic [REQ_W-1:0] REQ_TOP = '1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 16;
  localparam int FILL_ITEMS  = 1040;

  // One request as carried on the input stream.
  typedef struct {
    logic [REQ_W-1:0]  kind;
    logic [BYTE_W-1:0] byte_val;
    logic [ADDR_W-1:0] byte_addr;
    logic              rd_ok;
    logic [DATA_W-1:0] rd_val;
    logic [IDX_W-1:0]  idx;
  } scan_req_t;

  // One result as carried on the output stream.
  typedef struct {
    logic              match;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
    logic              full;
    logic              done;
  } scan_rsp_t;

  // Tracks the candidate list and predicts the result of every accepted request.
  class scanner_scoreboard;
    logic [DATA_W-1:0] search;
    logic [ADDR_W-1:0] cand[LIST_DEPTH];
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  rd_idx;
    logic [CNT_W-1:0]  orig;
    logic [WIN_W-1:0]  win;
    logic [1:0]        fill;
    logic              full_flag;
    scan_rsp_t         expected_q[$];
    int                errors = 0;

    function void reset();
      search    = '0;
      count     = '0;
      rd_idx    = '0;
      orig      = '0;
      win       = '0;
      fill      = '0;
      full_flag = 1'b0;
    endfunction

    function void set_search(logic [DATA_W-1:0] v);
      search = v;
    endfunction

    function void note_request(scan_req_t r);
      scan_rsp_t         e;
      logic [DATA_W-1:0] word;
      logic [ADDR_W-1:0] a;
      e.match = 1'b0;
      e.addr  = '0;
      e.done  = 1'b0;
      case (r.kind)
        REQ_CLEAR: begin
          count     = '0;
          full_flag = 1'b0;
          win       = '0;
          fill      = '0;
          rd_idx    = '0;
          orig      = '0;
        end
        REQ_SCAN: begin
          // A scan drops whatever part of a refine pass is still open.
          if (rd_idx < orig) begin
            rd_idx = '0;
            orig   = '0;
          end
          if (r.byte_addr[PAGE_BITS-1:0] == '0) fill = '0;
          if (fill == 2'd3) begin
            word = {r.byte_val, win};
            if (word == search) begin
              e.match = 1'b1;
              e.addr  = r.byte_addr - 32'd3;
              if (count < LIST_DEPTH) begin
                cand[count[LIST_AW-1:0]] = e.addr;
                count++;
              end else begin
                full_flag = 1'b1;
              end
            end
          end
          win = {r.byte_val, win[WIN_W-1:BYTE_W]};
          if (fill != 2'd3) fill++;
        end
        REQ_BEGIN: begin
          orig   = count;
          rd_idx = '0;
          count  = '0;
          if (orig == '0) e.done = 1'b1;
        end
        REQ_RESULT: begin
          // Compact in place: kept entries are written back at the new count.
          if (rd_idx < orig) begin
            a = cand[rd_idx[LIST_AW-1:0]];
            if (r.rd_ok && r.rd_val == search && count < LIST_DEPTH) begin
              cand[count[LIST_AW-1:0]] = a;
              count++;
              e.match = 1'b1;
              e.addr  = a;
            end
            rd_idx++;
            if (rd_idx == orig) begin
              e.done = 1'b1;
              rd_idx = '0;
              orig   = '0;
            end
          end
        end
        REQ_READ: begin
          if (r.idx < count) begin
            e.match = 1'b1;
            e.addr  = cand[r.idx];
          end
        end
        default: ;
      endcase
      e.count = count;
      e.full  = full_flag;
      expected_q.push_back(e);
    endfunction

    function void cmp(string field, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(scan_rsp_t got);
      scan_rsp_t e;
      if (expected_q.size() == 0) begin
        $error("result transfer with no expected result waiting");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("match", e.match, got.match);
      cmp("match_address", e.addr, got.addr);
      cmp("list_count", e.count, got.count);
      cmp("list_full", e.full, got.full);
      cmp("refine_done", e.done, got.done);
    endfunction

    function void finish_check();
      if (expected_q.size() != 0) begin
        $error("%0d expected results never arrived", expected_q.size());
        errors += expected_q.size();
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;

  scanner_scoreboard sb;
  bit calm      = 1'b0;
  bit hold_now  = 1'b0;
  bit hold_seen = 1'b0;
  int n_sent    = 0;

  dword_value_scan_and_refine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Request with every field random, so that unused fields toggle too.
  function automatic scan_req_t any_req();
    scan_req_t r;
    r.kind      = REQ_W'($urandom_range(0, REQ_TOP));
    r.byte_val  = BYTE_W'($urandom);
    r.byte_addr = $urandom;
    r.rd_ok     = 1'($urandom);
    r.rd_val    = $urandom;
    r.idx       = IDX_W'($urandom);
    return r;
  endfunction

  // Offer one request, idling at random first, and note it once transferred.
  task automatic send(scan_req_t r);
    while (!calm && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.kind;
    in_tdata  <= {5'b0, r.idx, r.rd_val, r.rd_ok, r.byte_addr, r.byte_val};
    do @(posedge clk); while (!in_tready);
    sb.note_request(r);
    n_sent++;
  endtask

  task automatic request(input logic [REQ_W-1:0] kind);
    scan_req_t r;
    r = any_req();
    r.kind = kind;
    send(r);
  endtask

  task automatic scan(input logic [ADDR_W-1:0] a, input logic [BYTE_W-1:0] b);
    scan_req_t r;
    r = any_req();
    r.kind      = REQ_SCAN;
    r.byte_addr = a;
    r.byte_val  = b;
    send(r);
  endtask

  task automatic refine_result(input logic ok, input logic [DATA_W-1:0] v);
    scan_req_t r;
    r = any_req();
    r.kind   = REQ_RESULT;
    r.rd_ok  = ok;
    r.rd_val = v;
    send(r);
  endtask

  task automatic read_entry(input logic [IDX_W-1:0] i);
    scan_req_t r;
    r = any_req();
    r.kind = REQ_READ;
    r.idx  = i;
    send(r);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_search(input logic [DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_search(v);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, one long hold-off, and calm stretches with none.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_now && !hold_seen) begin
        hold_seen = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  // Result monitor: every transfer on the output stream is checked.
  initial begin
    scan_rsp_t got;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready) begin
        got.match = out_tuser[0];
        got.addr  = out_tdata[31:0];
        got.count = out_tdata[42:32];
        got.full  = out_tdata[43];
        got.done  = out_tlast;
        sb.check_result(got);
      end
    end
  end

  // Watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // Main stimulus.
  initial begin
    logic [DATA_W-1:0] sv;
    logic [ADDR_W-1:0] a;
    int c;
    int cut;
    int len;
    int j;
    int start;
    int k;
    sb = new();
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_CLEAR;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    sb.reset();
    @(posedge clk);

    // Directed: empty list, stray refine result, unknown codes.
    read_entry('0);
    refine_result(1'b1, 32'h0);
    request(REQ_BEGIN);
    request(REQ_TOP);
    request(REQ_READ + 3'd1);
    drain();
    write_search(32'h4433_2211);
    // The word straddles a page start and must not match; the next one does.
    scan(32'h0000_0FFE, 8'h11);
    scan(32'h0000_0FFF, 8'h22);
    scan(32'h0000_1000, 8'h33);
    scan(32'h0000_1001, 8'h44);
    scan(32'h0000_1002, 8'h11);
    scan(32'h0000_1003, 8'h22);
    scan(32'h0000_1004, 8'h33);
    scan(32'h0000_1005, 8'h44);
    // Match at the very top of the address space.
    scan(32'hFFFF_FFFC, 8'h11);
    scan(32'hFFFF_FFFD, 8'h22);
    scan(32'hFFFF_FFFE, 8'h33);
    scan(32'hFFFF_FFFF, 8'h44);
    read_entry(10'd1);
    read_entry('1);
    // Refine keeps one entry and drops one after a failed read.
    request(REQ_BEGIN);
    refine_result(1'b1, 32'h4433_2211);
    refine_result(1'b0, 32'h4433_2211);
    // A scan in the middle of a refine cancels it.
    request(REQ_BEGIN);
    scan(32'h0000_2000, 8'hFF);
    request(REQ_CLEAR);

    // Fill the list past its depth with an all-zero search value, including
    // an out-of-order jump that makes the window start wrap below zero.
    // Neither side idles during the fill.
    drain();
    write_search('0);
    calm = 1'b1;
    a = 32'hFFFF_FC00;
    for (int i = 0; i < FILL_ITEMS; i++) begin
      if (i == FILL_ITEMS / 2) a = 32'h0000_0001;
      scan(a, 8'h00);
      a++;
    end
    calm = 1'b0;
    read_entry('1);
    request(REQ_BEGIN);
    for (int i = 0; i < 16; i++) refine_result($urandom_range(3) != 0, '0);
    scan(32'h0000_3000, 8'h5A);
    read_entry(10'd3);
    request(REQ_CLEAR);

    // Random phases, each under its own search value.
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph)
        0:       sv = '1;
        1:       sv = '0;
        3:       sv = {4{8'($urandom)}};
        default: sv = $urandom;
      endcase
      write_search(sv);
      calm     = (ph == 4 || ph == 5);
      hold_now = (ph == 2);
      request(REQ_CLEAR);
      start = n_sent;
      while (n_sent - start < PHASE_ITEMS) begin
        k = $urandom_range(99);
        if (k < 40) begin
          // Contiguous byte run with planted words, sometimes across a page.
          len = $urandom_range(6, 40);
          a = $urandom;
          if ($urandom_range(2) == 0) a = {a[31:12], 12'hFF0} + $urandom_range(15);
          j = 0;
          while (j < len) begin
            if ($urandom_range(3) == 0 && j + 4 <= len) begin
              for (int b = 0; b < 4; b++) begin
                scan(a, sv[8*b +: 8]);
                a++;
              end
              j += 4;
            end else begin
              if ($urandom_range(1) == 0) scan(a, sv[8*$urandom_range(3) +: 8]);
              else scan(a, BYTE_W'($urandom));
              a++;
              j++;
            end
          end
        end else if (k < 55) begin
          // Read back a few entries, mostly in range.
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(9) < 7) read_entry(IDX_W'($urandom_range(0, sb.count)));
            else read_entry(IDX_W'($urandom));
          end
        end else if (k < 80) begin
          // Refine pass, now and then cut short by a scan or a new begin.
          c = sb.count;
          request(REQ_BEGIN);
          cut = ($urandom_range(6) == 0 && c > 1) ? $urandom_range(1, c - 1) : c;
          for (int i = 0; i < cut; i++) begin
            if ($urandom_range(3) != 0) refine_result($urandom_range(9) != 0, sv);
            else refine_result($urandom_range(9) != 0, $urandom);
          end
          if (cut < c) begin
            if ($urandom_range(1) == 0) scan($urandom, BYTE_W'($urandom));
            else request(REQ_BEGIN);
          end
        end else if (k < 95) begin
          send(any_req());
        end else begin
          request(REQ_CLEAR);
        end
      end
    end
    calm = 1'b0;

    // Wait for the last results, bounded, then let the block idle before the check.
    in_tvalid <= 1'b0;
    k = 0;
    while (sb.expected_q.size() != 0 && k < 5000) begin
      @(posedge clk);
      k++;
    end
    repeat (8) @(posedge clk);
    sb.finish_check();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
